[hw/rtl/prpw_pkg.sv]
`timescale 1ns / 1ps

package prpw_pkg;

    typedef struct packed {
        logic valid;
        logic zero;
    } prpw_ctl_t;

    localparam logic [7:0] CFG_FRAME_COLS = 8'd0;
    localparam logic [7:0] CFG_RAMP_X     = 8'd1;
    localparam logic [7:0] CFG_RAMP_Y     = 8'd2;

    localparam logic [12:0] FRAME_COLS_RESET = 13'd1024;
    localparam logic [31:0] HALF_TURN        = 32'h8000_0000;
    localparam logic [31:0] ROUND_HALF       = 32'h0000_8000;
    localparam int          MAX_STAGES       = 24;

    // atan(2^-i) in 2^-32 turn units
    localparam logic [31:0] ATAN_TURNS [MAX_STAGES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

[hw/rtl/prpw_ramp_gen.sv]
`timescale 1ns / 1ps

module prpw_ramp_gen #(
    parameter int MAX_COLS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        frame_start,
    input  logic [12:0] frame_cols,
    input  logic [31:0] ramp_x,
    input  logic [31:0] ramp_y,
    output logic [31:0] pixel_ramp
);

    localparam int CNT_W = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;

    logic [CNT_W-1:0] column_count_reg, column_count_next, cnt_base;
    logic [31:0]      row_ramp_acc_reg, row_ramp_acc_next, row_base;
    logic [31:0]      pixel_ramp_acc_reg, pixel_ramp_acc_next, pix_base;
    logic [31:0]      fc_ext, eff_cols, cnt_inc, row_step;
    logic             row_end;

    always_comb begin
        cnt_base = frame_start ? '0 : column_count_reg;
        row_base = frame_start ? '0 : row_ramp_acc_reg;
        pix_base = frame_start ? '0 : pixel_ramp_acc_reg;

        fc_ext = 32'(frame_cols);
        if (fc_ext == 32'd0) begin
            eff_cols = 32'd1;
        end else if (fc_ext > 32'(MAX_COLS)) begin
            eff_cols = 32'(MAX_COLS);
        end else begin
            eff_cols = fc_ext;
        end

        cnt_inc  = 32'(cnt_base) + 32'd1;
        row_end  = (cnt_inc >= eff_cols);
        row_step = row_base + ramp_y;

        if (row_end) begin
            column_count_next   = '0;
            row_ramp_acc_next   = row_step;
            pixel_ramp_acc_next = row_step;
        end else begin
            column_count_next   = cnt_inc[CNT_W-1:0];
            row_ramp_acc_next   = row_base;
            pixel_ramp_acc_next = pix_base + ramp_x;
        end
    end

    assign pixel_ramp = pix_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg   <= '0;
            row_ramp_acc_reg   <= '0;
            pixel_ramp_acc_reg <= '0;
        end else if (advance) begin
            column_count_reg   <= column_count_next;
            row_ramp_acc_reg   <= row_ramp_acc_next;
            pixel_ramp_acc_reg <= pixel_ramp_acc_next;
        end
    end

endmodule

[hw/rtl/prpw_cordic_cell.sv]
`timescale 1ns / 1ps

module prpw_cordic_cell #(
    parameter int XW    = 34,
    parameter int STAGE = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  prpw_pkg::prpw_ctl_t     in_ctl,
    input  logic signed [XW-1:0]    in_x,
    input  logic signed [XW-1:0]    in_y,
    input  logic [31:0]             in_ang,
    output prpw_pkg::prpw_ctl_t     out_ctl,
    output logic signed [XW-1:0]    out_x,
    output logic signed [XW-1:0]    out_y,
    output logic [31:0]             out_ang
);

    localparam logic [31:0] STEP_ANGLE = prpw_pkg::ATAN_TURNS[STAGE];

    prpw_pkg::prpw_ctl_t     ctl_reg;
    logic signed [XW-1:0]    x_reg, x_next, y_reg, y_next, dx, dy;
    logic [31:0]             ang_reg, ang_next;

    always_comb begin
        dx = in_y >>> STAGE;
        dy = in_x >>> STAGE;
        if (in_ctl.zero) begin
            x_next   = in_x;
            y_next   = in_y;
            ang_next = in_ang;
        end else if (in_y > 0) begin
            x_next   = in_x + dx;
            y_next   = in_y - dy;
            ang_next = in_ang + STEP_ANGLE;
        end else begin
            x_next   = in_x - dx;
            y_next   = in_y + dy;
            ang_next = in_ang - STEP_ANGLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ang_reg <= ang_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_x   = x_reg;
    assign out_y   = y_reg;
    assign out_ang = ang_reg;

endmodule

[hw/rtl/phase_ramp_remove_and_wrap_unit.sv]
`timescale 1ns / 1ps
// pipeline: one pre-rotation stage, one register per cordic cell, one output register
// throughput: one item per cycle; the whole chain holds while the output is stalled
// reset: synchronous active-low aresetn clears valid bits, position counters,
// ramp accumulators and config (frame_cols 1024, ramps 0)

module phase_ramp_remove_and_wrap_unit #(
    parameter int MAX_COLS      = 4096,
    parameter int SAMPLE_WIDTH  = 24,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // sample_real, sample_imag
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
    // frame_start
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // wrapped_phase
    output logic [15:0]                           m_tdata,
    // zero_sample
    output logic [0:0]                            m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [7:0]                            cfg_index,
    input  logic [31:0]                           cfg_data
);

    localparam int XW = SAMPLE_WIDTH + 10;

    logic [12:0] frame_cols_reg;
    logic [31:0] ramp_x_reg, ramp_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cols_reg <= prpw_pkg::FRAME_COLS_RESET;
            ramp_x_reg     <= '0;
            ramp_y_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                prpw_pkg::CFG_FRAME_COLS: frame_cols_reg <= cfg_data[12:0];
                prpw_pkg::CFG_RAMP_X:     ramp_x_reg     <= cfg_data;
                prpw_pkg::CFG_RAMP_Y:     ramp_y_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en, accept;
    prpw_pkg::prpw_ctl_t out_ctl_reg;

    assign en       = !out_ctl_reg.valid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    logic [31:0] pixel_ramp;

    prpw_ramp_gen #(
        .MAX_COLS(MAX_COLS)
    ) u_ramp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (accept),
        .frame_start (s_tuser[0]),
        .frame_cols  (frame_cols_reg),
        .ramp_x      (ramp_x_reg),
        .ramp_y      (ramp_y_reg),
        .pixel_ramp  (pixel_ramp)
    );

    logic [SAMPLE_WIDTH-1:0] re_raw, im_raw;
    logic signed [XW-1:0]    re_ext, im_ext, pre_x_next, pre_y_next;
    logic [31:0]             pre_ang_next;
    logic                    pre_zero;

    always_comb begin
        re_raw   = s_tdata[SAMPLE_WIDTH-1:0];
        im_raw   = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        re_ext   = {{(XW-SAMPLE_WIDTH-8){re_raw[SAMPLE_WIDTH-1]}}, re_raw, 8'd0};
        im_ext   = {{(XW-SAMPLE_WIDTH-8){im_raw[SAMPLE_WIDTH-1]}}, im_raw, 8'd0};
        pre_zero = (re_raw == '0) && (im_raw == '0);
        if (re_ext < 0) begin
            pre_x_next   = -re_ext;
            pre_y_next   = -im_ext;
            pre_ang_next = prpw_pkg::HALF_TURN - pixel_ramp;
        end else begin
            pre_x_next   = re_ext;
            pre_y_next   = im_ext;
            pre_ang_next = 32'd0 - pixel_ramp;
        end
    end

    prpw_pkg::prpw_ctl_t  ctl_chain [CORDIC_STAGES+1];
    logic signed [XW-1:0] x_chain   [CORDIC_STAGES+1];
    logic signed [XW-1:0] y_chain   [CORDIC_STAGES+1];
    logic [31:0]          ang_chain [CORDIC_STAGES+1];

    prpw_pkg::prpw_ctl_t  pre_ctl_reg;
    logic signed [XW-1:0] pre_x_reg, pre_y_reg;
    logic [31:0]          pre_ang_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_ctl_reg <= '0;
        end else if (en) begin
            pre_ctl_reg.valid <= s_tvalid;
            pre_ctl_reg.zero  <= pre_zero;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_x_reg   <= pre_x_next;
            pre_y_reg   <= pre_y_next;
            pre_ang_reg <= pre_ang_next;
        end
    end

    assign ctl_chain[0] = pre_ctl_reg;
    assign x_chain[0]   = pre_x_reg;
    assign y_chain[0]   = pre_y_reg;
    assign ang_chain[0] = pre_ang_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        prpw_cordic_cell #(
            .XW    (XW),
            .STAGE (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_ctl  (ctl_chain[i]),
            .in_x    (x_chain[i]),
            .in_y    (y_chain[i]),
            .in_ang  (ang_chain[i]),
            .out_ctl (ctl_chain[i+1]),
            .out_x   (x_chain[i+1]),
            .out_y   (y_chain[i+1]),
            .out_ang (ang_chain[i+1])
        );
    end

    logic [31:0] rounded;
    logic [15:0] phase_reg;

    assign rounded = ang_chain[CORDIC_STAGES] + prpw_pkg::ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_ctl_reg <= '0;
        end else if (en) begin
            out_ctl_reg <= ctl_chain[CORDIC_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            phase_reg <= rounded[31:16];
        end
    end

    assign m_tvalid   = out_ctl_reg.valid;
    assign m_tdata    = phase_reg;
    assign m_tuser[0] = out_ctl_reg.zero;

endmodule

[hw/rtl/prpw_checker.sv]
`timescale 1ns / 1ps

module prpw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        cfg_ready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input not ready with empty output register");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind phase_ramp_remove_and_wrap_unit prpw_checker u_prpw_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_ready (cfg_ready)
);
